>>> design/cma_pkg.sv
// Package for the centered moving average unit.
// Holds the configuration register width and the sequencer state type.
// No dependencies.
package cma_pkg;

	// Width of the window length configuration register.
	localparam int WL_W = 6;

	// Sequencer states, one-hot coded.
	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SUB       = 6'b000010,
		ST_PICK      = 6'b000100,
		ST_DIV       = 6'b001000,
		ST_FLUSH_RD  = 6'b010000,
		ST_FLUSH_OUT = 6'b100000
	} cma_state_t;

endpackage

>>> design/cma_if.sv
// Channel interfaces of the centered moving average unit: sample requests,
// result requests and the window length write channel.
// Depends on cma_pkg for the register width.
interface cma_sample_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   track_end;

	modport source (output valid, output sample, output track_end, input ready);
	modport sink   (input valid, input sample, input track_end, output ready);
endinterface

interface cma_result_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] value;
	logic                   averaged;
	logic                   last;

	modport source (output valid, output value, output averaged, output last, input ready);
	modport sink   (input valid, input value, input averaged, input last, output ready);
endinterface

interface cma_cfg_if import cma_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [WL_W-1:0] window_length;

	modport source (output valid, output window_length, input ready);
	modport sink   (input valid, input window_length, output ready);
endinterface

>>> design/cma_ring.sv
// Sample ring memory of the centered moving average unit.
// One write port and one registered read port; no dependencies.
module cma_ring #(
	parameter int DEPTH  = 33,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/cma_serial_div.sv
// Bit-serial restoring divider of the centered moving average unit.
// One quotient bit per cycle; no dependencies.
module cma_serial_div #(
	parameter int DIVIDEND_W = 22,
	parameter int DIVISOR_W  = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// The dividend leaves at the top of num_q while quotient bits enter at the bottom.
	assign trial = {rem_q, num_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			num_q  <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
			cnt_q  <= CNT_W'(DIVIDEND_W);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			num_q  <= {num_q[DIVIDEND_W-2:0], fits};
			rem_q  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

	// The partial remainder always stays below the divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("partial remainder reached the divisor");

	// The final step ends the division.
	a_last_step_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == CNT_W'(1)) |=> !busy_q)
		else $error("divider ran past its last step");

endmodule

>>> design/centered_moving_average_unit.sv
// Top level of the centered moving average unit.
// Depends on cma_pkg, cma_if, cma_ring and cma_serial_div.
//
// Usage: the samples channel takes one frame value per request, with track_end
// on the final frame of a class track. The results channel gives one frame for
// each frame of a track: the truncated mean of the 2*half+1 frames centered on
// it, or the frame unchanged near either end of the track, with last on the
// final frame. The user must write window_length on cfg only while the block is
// idle; the block does not enforce this. A write also clears the track state.
// With a window below two every frame passes straight through, one request per
// cycle while the receiver keeps up, the result showing in the next cycle.
// Otherwise results lag by half frames. An averaged frame passes the subtract
// and pick steps and the bit-serial divider (one quotient bit per cycle); an
// early passthrough frame needs subtract and pick, and each frame flushed by
// track_end a read and an output step, set by the single ring read port. One
// request is in work at a time. Reset zeroes window_length and clears the track
// state; the sample ring is not cleared: only current-track entries are read.
// A stalled result waits in the output register and the sequencer holds at its
// next result step; in passthrough samples.ready stays low until it is taken.
module centered_moving_average_unit import cma_pkg::*; #(
	parameter int MAX_WINDOW  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	cma_cfg_if.sink             cfg,
	cma_sample_if.sink          samples,
	cma_result_if.source        results
);

	// The ring holds one full window plus the entry about to drop out.
	localparam int DEPTH = MAX_WINDOW + 1;
	localparam int PTR_W = $clog2(DEPTH);
	// Counts up to the tap count, which may equal the ring depth.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int T_W   = $clog2(2 * DEPTH);
	// Room for a full window sum plus the sample added before the oldest leaves.
	localparam int SUM_W = SAMPLE_BITS + CNT_W;

	cma_state_t             state_q;
	logic [CNT_W-1:0]       half_q;
	logic [CNT_W-1:0]       taps_q;
	logic [PTR_W-1:0]       wp_q;
	logic [CNT_W-1:0]       fs_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] s_q;
	logic                   end_q;
	logic                   sub_q;
	logic [CNT_W-1:0]       rem_q;

	logic                   res_valid_q;
	logic [SAMPLE_BITS-1:0] res_value_q;
	logic                   res_avg_q;
	logic                   res_last_q;

	logic                   in_fire;
	logic                   cfg_fire;
	logic                   pass_mode;
	logic                   out_free;
	logic                   full;
	logic                   has_main;
	logic                   main_done;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] out_value;
	logic                   out_avg;
	logic                   out_last;
	logic                   div_start;
	logic                   div_busy;
	logic [SUM_W-1:0]       quotient;
	logic                   rd_en;
	logic [PTR_W-1:0]       rd_addr;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [WL_W-1:0]        win_clamped;
	logic [WL_W-1:0]        half_cfg;
	logic [CNT_W-1:0]       rem_start;

	// Ring position of the sample written age requests before the one at ptr.
	function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] ptr,
			input logic [CNT_W-1:0] age);
		logic [T_W-1:0] t;
		t = T_W'(ptr) + T_W'(DEPTH) - T_W'(age);
		if (t >= T_W'(DEPTH)) begin
			t = t - T_W'(DEPTH);
		end
		return t[PTR_W-1:0];
	endfunction

	assign pass_mode = half_q == '0;
	assign out_free  = !res_valid_q || results.ready;
	assign full      = fs_q >= taps_q;
	assign has_main  = fs_q > half_q;
	assign rem_start = (fs_q < half_q) ? fs_q : half_q;

	assign cfg.ready     = 1'b1;
	assign cfg_fire      = cfg.valid;
	assign samples.ready = (state_q == ST_IDLE) && (!pass_mode || out_free);
	assign in_fire       = samples.valid && samples.ready;

	// Window lengths past MAX_WINDOW act as the largest window.
	assign win_clamped = (cfg.window_length > WL_W'(MAX_WINDOW)) ?
		WL_W'(MAX_WINDOW) : cfg.window_length;
	assign half_cfg    = (win_clamped < WL_W'(2)) ? '0 : (win_clamped >> 1);

	cma_ring #(
		.DEPTH  (DEPTH),
		.DATA_W (SAMPLE_BITS)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ST_SUB),
		.wr_addr (wp_q),
		.wr_data (s_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cma_serial_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (taps_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Ring reads, divider start and result loads for each step of a request.
	always_comb begin
		out_load  = 1'b0;
		out_value = rd_data;
		out_avg   = 1'b0;
		out_last  = 1'b0;
		div_start = 1'b0;
		main_done = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = ring_back(wp_q, taps_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (pass_mode) begin
						out_load  = 1'b1;
						out_value = samples.sample;
						out_last  = samples.track_end;
					end else begin
						// Fetch the frame that drops out of a full window.
						rd_en = 1'b1;
					end
				end
			end
			ST_SUB: begin
				// Fetch the frame at the center, for an early passthrough.
				rd_en   = 1'b1;
				rd_addr = ring_back(wp_q, half_q);
			end
			ST_PICK: begin
				if (has_main && full) begin
					div_start = 1'b1;
				end else if (has_main) begin
					if (out_free) begin
						out_load  = 1'b1;
						main_done = 1'b1;
					end
				end else begin
					main_done = 1'b1;
				end
			end
			ST_DIV: begin
				if (!div_busy && out_free) begin
					out_load  = 1'b1;
					out_value = quotient[SAMPLE_BITS-1:0];
					out_avg   = 1'b1;
					main_done = 1'b1;
				end
			end
			ST_FLUSH_RD: begin
				rd_en   = 1'b1;
				rd_addr = ring_back(wp_q, rem_q - CNT_W'(1));
			end
			ST_FLUSH_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = rem_q == '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			half_q      <= '0;
			taps_q      <= CNT_W'(1);
			wp_q        <= '0;
			fs_q        <= '0;
			sum_q       <= '0;
			s_q         <= '0;
			end_q       <= 1'b0;
			sub_q       <= 1'b0;
			rem_q       <= '0;
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			res_avg_q   <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// In passthrough mode the track state stays clear, so nothing changes.
					if (in_fire && !pass_mode) begin
						s_q     <= samples.sample;
						end_q   <= samples.track_end;
						sum_q   <= sum_q + SUM_W'(samples.sample);
						sub_q   <= full;
						if (!full) begin
							fs_q <= fs_q + CNT_W'(1);
						end
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					if (sub_q) begin
						sum_q <= sum_q - SUM_W'(rd_data);
					end
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
				end
				ST_FLUSH_RD: begin
					rem_q   <= rem_q - CNT_W'(1);
					state_q <= ST_FLUSH_OUT;
				end
				ST_FLUSH_OUT: begin
					if (out_free) begin
						if (rem_q == '0) begin
							sum_q   <= '0;
							fs_q    <= '0;
							wp_q    <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FLUSH_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// After the centered frame, either flush the held frames or move on.
			if (main_done) begin
				if (end_q) begin
					rem_q   <= rem_start;
					state_q <= ST_FLUSH_RD;
				end else begin
					wp_q    <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
					state_q <= ST_IDLE;
				end
			end

			if (out_load) begin
				res_valid_q <= 1'b1;
				res_value_q <= out_value;
				res_avg_q   <= out_avg;
				res_last_q  <= out_last;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end

			// A window write abandons any track and starts fresh.
			if (cfg_fire) begin
				half_q  <= CNT_W'(half_cfg);
				taps_q  <= CNT_W'({half_cfg, 1'b1});
				sum_q   <= '0;
				fs_q    <= '0;
				wp_q    <= '0;
				state_q <= ST_IDLE;
			end
		end
	end

	assign results.valid    = res_valid_q;
	assign results.value    = res_value_q;
	assign results.averaged = res_avg_q;
	assign results.last     = res_last_q;

	// The frame count saturates at the tap count.
	a_fs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fs_q <= taps_q)
		else $error("frame count passed the tap count");

	// A flush step always has a held frame left to read.
	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH_RD) |-> (rem_q != '0 && rem_q <= half_q))
		else $error("flush count out of range");

	// The divider is only started when it is free.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule

>>> bench/cma_checker.sv
// Checker for the centered moving average unit: watches the window length,
// sample and result channels, predicts every result frame and compares it.
// Depends on cma_pkg for the register width.
module cma_checker import cma_pkg::*; #(
	parameter int MAX_WINDOW  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [WL_W-1:0]        cfg_window,
	input  logic                   smp_valid,
	input  logic                   smp_ready,
	input  logic [SAMPLE_BITS-1:0] smp_value,
	input  logic                   smp_end,
	input  logic                   res_valid,
	input  logic                   res_ready,
	input  logic [SAMPLE_BITS-1:0] res_value,
	input  logic                   res_averaged,
	input  logic                   res_last,
	output int                     mismatches,
	output int                     outstanding
);

	localparam int RING_DEPTH = MAX_WINDOW + 1;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic                   averaged;
		logic                   last;
	} frame_t;

	logic [WL_W-1:0]        window_reg;
	logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
	logic [SAMPLE_BITS+5:0] ring_sum;
	int                     frames_held;
	int                     wr_ptr;
	frame_t                 expected_frames [$];

	function automatic int window_half();
		int w;
		w = (window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
		return (w < 2) ? 0 : w / 2;
	endfunction

	// Sample written age frames before the current write position.
	function automatic logic [SAMPLE_BITS-1:0] held_back(input int age);
		return ring[(wr_ptr + RING_DEPTH - (age % RING_DEPTH)) % RING_DEPTH];
	endfunction

	task automatic clear_track();
		foreach (ring[i])
			ring[i] = '0;
		ring_sum    = '0;
		frames_held = 0;
		wr_ptr      = 0;
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic predict_frames(input logic [SAMPLE_BITS-1:0] s, input logic is_end);
		int          half;
		int          taps;
		int          rem;
		logic [31:0] quot;
		frame_t      f;
		frame_t      fresh [$];
		half = window_half();
		taps = 2 * half + 1;
		if (half == 0) begin
			f = '{s, 1'b0, is_end};
			expected_frames.push_back(f);
			if (is_end)
				clear_track();
			return;
		end
		if (frames_held >= taps)
			ring_sum = ring_sum - held_back(taps);
		ring[wr_ptr] = s;
		ring_sum     = ring_sum + s;
		if (frames_held < taps)
			frames_held++;
		if (frames_held >= half + 1) begin
			if (frames_held >= taps) begin
				quot = ring_sum / taps;
				f    = '{quot[SAMPLE_BITS-1:0], 1'b1, 1'b0};
			end else begin
				f = '{held_back(half), 1'b0, 1'b0};
			end
			fresh.push_back(f);
		end
		if (is_end) begin
			// Flush the frames still held back by the lag.
			rem = (frames_held < half) ? frames_held : half;
			while (rem > 0) begin
				rem--;
				f = '{held_back(rem), 1'b0, 1'b0};
				fresh.push_back(f);
			end
			if (fresh.size() > 0)
				fresh[fresh.size()-1].last = 1'b1;
			clear_track();
		end else begin
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
		end
		foreach (fresh[i])
			expected_frames.push_back(fresh[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			window_reg = '0;
			clear_track();
			expected_frames.delete();
			mismatches = 0;
		end else begin
			// Results leaving at this edge belong to earlier requests.
			if (res_valid && res_ready) begin
				if (expected_frames.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %h", res_value));
				end else begin
					want = expected_frames.pop_front();
					if (res_value !== want.value)
						report_mismatch($sformatf("value %h, expected %h",
							res_value, want.value));
					if (res_averaged !== want.averaged)
						report_mismatch($sformatf("averaged %b, expected %b",
							res_averaged, want.averaged));
					if (res_last !== want.last)
						report_mismatch($sformatf("last %b, expected %b",
							res_last, want.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				window_reg = cfg_window;
				clear_track();
			end
			if (smp_valid && smp_ready)
				predict_frames(smp_value, smp_end);
		end
		outstanding = expected_frames.size();
	end

endmodule

>>> bench/testbench.sv
// Top of the centered moving average testbench: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on cma_pkg, cma_if, the unit itself and cma_checker.
module testbench;
	import cma_pkg::*;

	localparam int SAMPLE_BITS   = 16;
	localparam int MAX_WINDOW    = 32;
	// Long enough for an averaged frame to finish, with margin.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 450;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 400000;

	// How the result receiver behaves over one stretch of cycles.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PATTERN,
		RX_HOLD
	} rx_mode_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   requests_sent;
	int   burst_left;
	int   cycles;
	bit   long_hold_done;

	cma_cfg_if                                  cfg_ch ();
	cma_sample_if #(.SAMPLE_BITS(SAMPLE_BITS))  smp_ch ();
	cma_result_if #(.SAMPLE_BITS(SAMPLE_BITS))  res_ch ();

	centered_moving_average_unit #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.samples(smp_ch),
		.results(res_ch)
	);

	// The checker sees every handshake and tells the top how many result
	// frames are still owed and how many mismatches it found.
	cma_checker #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) avg_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_ch.valid),
		.cfg_ready   (cfg_ch.ready),
		.cfg_window  (cfg_ch.window_length),
		.smp_valid   (smp_ch.valid),
		.smp_ready   (smp_ch.ready),
		.smp_value   (smp_ch.sample),
		.smp_end     (smp_ch.track_end),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.res_value   (res_ch.value),
		.res_averaged(res_ch.averaged),
		.res_last    (res_ch.last),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Waits until every predicted frame has come out, then lets the block
	// finish any request that produces no result (a frame taken early in a
	// track only fills the window). Only then is the block truly idle.
	task automatic wait_idle();
		smp_ch.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// Writes the window length while idle. A write also clears the track in
	// progress, so a partial track sent before it yields nothing more.
	task automatic write_window(input logic [WL_W-1:0] w);
		wait_idle();
		cfg_ch.valid         <= 1'b1;
		cfg_ch.window_length <= w;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Offers one sample request and returns at the falling edge after it is
	// taken. Requests come in bursts; between bursts valid may drop for a random
	// gap. Within a burst valid stays high from one request to the next.
	task automatic send_request(input logic [SAMPLE_BITS-1:0] s, input logic is_end);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				smp_ch.valid <= 1'b0;
				@(negedge clk);
			end
			// Now and then a long burst leaves the sender without any idling.
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 10);
		end
		smp_ch.valid     <= 1'b1;
		smp_ch.sample    <= s;
		smp_ch.track_end <= is_end;
		do
			@(posedge clk);
		while (!smp_ch.ready);
		requests_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Sends one track of len frames. A saturated track holds every sample at
	// full scale, which drives the running sum to its largest value.
	task automatic send_track(input int len, input bit close);
		bit saturate;
		saturate = ($urandom_range(0, 5) == 0);
		for (int i = 0; i < len; i++) begin
			if (saturate)
				send_request('1, close && (i == len - 1));
			else
				case ($urandom_range(0, 7))
					0:       send_request('0, close && (i == len - 1));
					1:       send_request('1, close && (i == len - 1));
					default: send_request(SAMPLE_BITS'($urandom_range(0, 65535)),
						close && (i == len - 1));
				endcase
		end
	endtask

	// Result receiver. It runs through stretches of free flow, random stalls,
	// a regular pattern and outright holds. Once, after enough requests have
	// gone in, it holds off for a long stretch while the sender keeps
	// offering, so the block fills up and drops samples.ready.
	initial begin
		rx_mode_t mode;
		int       stretch;
		int       period;
		res_ch.ready = 1'b0;
		forever begin
			if (!long_hold_done && requests_sent >= 150) begin
				mode           = RX_HOLD;
				stretch        = LONG_HOLD;
				long_hold_done = 1'b1;
			end else begin
				mode    = rx_mode_t'($urandom_range(0, 3));
				stretch = (mode == RX_HOLD) ? $urandom_range(20, 100)
					: $urandom_range(5, 60);
			end
			period = $urandom_range(2, 6);
			for (int k = 0; k < stretch; k++) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:    res_ch.ready <= 1'b1;
					RX_RANDOM:  res_ch.ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: res_ch.ready <= (k % period == 0);
					default:    res_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	// Watchdog: a hung handshake or a result that never comes ends here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [WL_W-1:0] w;
		int              clamp;
		int              taps;
		int              len;
		int              n_tracks;
		int              random_goal;

		arst_n               = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.window_length = '0;
		smp_ch.valid         = 1'b0;
		smp_ch.sample        = '0;
		smp_ch.track_end     = 1'b0;
		requests_sent        = 0;
		burst_left           = 0;
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Window of zero straight out of reset: every frame passes through
		// at once, and last follows track_end.
		send_request(16'hFFFF, 1'b0);
		send_request(16'h0000, 1'b1);
		// Window of one behaves the same.
		write_window(WL_W'(1));
		send_request(16'h8001, 1'b1);
		// Three taps: frames two through four are averaged, the ends pass.
		write_window(WL_W'(3));
		send_request(16'hFFFF, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'hFFFF, 1'b1);
		// A one-frame track is shorter than the window and only passes.
		send_request(16'h7FFF, 1'b1);
		// A window above the maximum is clamped; a short track passes whole.
		write_window('1);
		send_request(16'h0001, 1'b0);
		send_request(16'hFFFE, 1'b0);
		send_request(16'h0000, 1'b1);
		// Abandon a track part way: the write clears the two held frames.
		write_window(WL_W'(4));
		send_request(16'h1234, 1'b0);
		send_request(16'hABCD, 1'b0);
		// An even window uses one extra tap.
		write_window(WL_W'(2));
		send_request(16'h0005, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h0003, 1'b1);

		// Random phases: each one picks a window, then sends a few tracks.
		// Most windows are small so that averaged frames are frequent; the
		// maximum and the clamped range come up regularly.
		random_goal = requests_sent + RANDOM_ITEMS;
		while (requests_sent < random_goal) begin
			case ($urandom_range(0, 9))
				0:       w = WL_W'($urandom_range(0, 1));
				1:       w = WL_W'(MAX_WINDOW);
				2:       w = WL_W'($urandom_range(MAX_WINDOW + 1, 63));
				3:       w = WL_W'($urandom_range(13, MAX_WINDOW - 1));
				default: w = WL_W'($urandom_range(2, 12));
			endcase
			write_window(w);
			clamp    = (w > MAX_WINDOW) ? MAX_WINDOW : int'(w);
			taps     = (clamp < 2) ? 1 : 2 * (clamp / 2) + 1;
			n_tracks = $urandom_range(1, 4);
			repeat (n_tracks) begin
				// A third of the tracks are at least a full window long, so long
				// windows also see averaged frames.
				if ($urandom_range(0, 2) == 0)
					len = taps + $urandom_range(0, 10);
				else
					len = $urandom_range(1, taps + 10);
				send_track(len, 1'b1);
			end
			// Sometimes leave a track open for the next write to abandon.
			if ($urandom_range(0, 7) == 0)
				send_track($urandom_range(1, taps), 1'b0);
		end

		wait_idle();
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
design/cma_pkg.sv
design/cma_if.sv
design/cma_ring.sv
design/cma_serial_div.sv
design/centered_moving_average_unit.sv
bench/cma_checker.sv
bench/testbench.sv
